[hw/rtl/fwf_pkg.sv]
// Shared types, constants and window arithmetic of the flash window finder.
`timescale 1ns / 1ps

package fwf_pkg;

  // Field widths
  localparam int unsigned SampleW  = 20;
  localparam int unsigned BinW     = 10;
  localparam int unsigned PeW      = 25;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned PeMinW   = 20;
  localparam int unsigned MultW    = 6;
  localparam int unsigned PreW     = 4;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_CHANNELS_DEF = 32;
  localparam int unsigned RESULT_DEPTH_DEF = 4;

  localparam logic [BinW-1:0] BinMax = '1;
  localparam logic [PeW-1:0]  PeMax  = '1;

  // Register reset values
  localparam logic [LevelW-1:0] SampleFloorRst = 16'd51;
  localparam logic [LevelW-1:0] HitLevelRst    = 16'd384;
  localparam logic [PeMinW-1:0] PeMinRst       = 20'd1536;
  localparam logic [MultW-1:0]  MultMinRst     = 6'd3;
  localparam logic [BinW-1:0]   WindowBinsRst  = 10'd78;
  localparam logic [BinW-1:0]   MinGapRst      = 10'd4;
  localparam logic [PreW-1:0]   PreBinsRst     = 4'd2;
  localparam logic [BinW-1:0]   FrameBinsRst   = 10'd250;

  // Register map, word index = paddr[4:2]
  typedef enum logic [RegIdxW-1:0] {
    REG_SAMPLE_FLOOR = 3'd0,
    REG_HIT_LEVEL    = 3'd1,
    REG_PE_MIN       = 3'd2,
    REG_MULT_MIN     = 3'd3,
    REG_WINDOW_BINS  = 3'd4,
    REG_MIN_GAP      = 3'd5,
    REG_PRE_BINS     = 3'd6,
    REG_FRAME_BINS   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] sample_floor;
    logic [LevelW-1:0] hit_level;
    logic [PeMinW-1:0] pe_min;
    logic [MultW-1:0]  mult_min;
    logic [BinW-1:0]   window_bins;
    logic [BinW-1:0]   min_gap;
    logic [PreW-1:0]   pre_bins;
    logic [BinW-1:0]   frame_bins;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_channel;
    logic                      last_bin;
  } in_item_t;

  typedef struct packed {
    logic [BinW-1:0] window_start;
    logic [BinW-1:0] window_end;
    logic [BinW-1:0] trigger_bin;
    logic [PeW-1:0]  trigger_pe;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic [BinW-1:0] first_bin;
    logic [BinW-1:0] end_bin;
  } window_t;

  // Window of a flash triggered at trig_bin; capped also by the next trigger if asked
  function automatic window_t calc_window(input logic [BinW-1:0] trig_bin,
                                          input logic [BinW-1:0] next_bin,
                                          input logic            capped,
                                          input cfg_t            cfg);
    logic signed [BinW+1:0] start_s;
    logic signed [BinW+1:0] end_s;
    logic signed [BinW+1:0] cap_s;
    window_t                win;
    start_s = $signed({2'b00, trig_bin}) - $signed({{(BinW+2-PreW){1'b0}}, cfg.pre_bins});
    if (start_s < $signed({(BinW+2){1'b0}})) begin
      start_s = '0;
    end
    end_s = start_s + $signed({2'b00, cfg.window_bins});
    if (end_s > $signed({2'b00, cfg.frame_bins})) begin
      end_s = $signed({2'b00, cfg.frame_bins});
    end
    cap_s = $signed({2'b00, next_bin}) - $signed({{(BinW+2-PreW){1'b0}}, cfg.pre_bins});
    if (capped && (end_s > cap_s)) begin
      end_s = cap_s;
    end
    if (end_s < start_s) begin
      end_s = start_s;
    end
    win.first_bin = start_s[BinW-1:0];
    win.end_bin   = end_s[BinW-1:0];
    return win;
  endfunction

endpackage

[hw/rtl/pmt_flash_window_finder.sv]
// Top level: per-bin PE and multiplicity accumulation, flash rules and result queue.
// Flow: a transferred sample is held in the item register and judged there; its results
//   are written into the result queue and offered on the output from its storage.
// Throughput: one sample per cycle; the item register waits only while the result
//   queue lacks room for two results, set by the output side draining one per transfer.
// Reset: accumulators, bin counter, pending flash and queue clear; registers take defaults.
`timescale 1ns / 1ps

module pmt_flash_window_finder #(
  parameter int unsigned MaxChannels = fwf_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned ResultDepth = fwf_pkg::RESULT_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fwf_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fwf_pkg::result_t              out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fwf_pkg::ApbDataW-1:0]  pwdata,
  output logic [fwf_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import fwf_pkg::*;

  localparam int unsigned FireW = $clog2(MaxChannels + 1);
  localparam int unsigned CmpW  = (FireW > MultW) ? FireW : MultW;

  cfg_t cfg;

  fwf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Item register
  in_item_t item_q;
  logic     item_valid_q;
  logic     room2;
  logic     load, proc;

  assign proc       = item_valid_q && room2;
  assign in_stall_o = item_valid_q && !room2;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (load) begin
      item_valid_q <= 1'b1;
    end else if (proc) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  // Bin and flash state
  logic [BinW-1:0]  bin_q, bin_d;
  logic [PeW-1:0]   pe_q, pe_d;
  logic [FireW-1:0] fired_q, fired_d;
  logic             pend_q, pend_d;
  logic [BinW-1:0]  pend_bin_q, pend_bin_d;
  logic [PeW-1:0]   pend_pe_q, pend_pe_d;

  logic             s_pos, above_floor, above_hit;
  logic [PeW:0]     pe_sum;
  logic [PeW-1:0]   pe_new;
  logic [FireW-1:0] fired_new;
  logic             end_bin, end_frame;
  logic             trig, take;
  logic [BinW-1:0]  bin_gap;
  logic             new_flash;
  logic [BinW-1:0]  flush_bin;
  window_t          win_close, win_flush;
  result_t          res_close, res_flush;
  logic             emit_close, emit_flush;
  logic [1:0]       push_cnt;
  result_t          wdata0, wdata1;

  always_comb begin
    // Sample thresholds; nonpositive samples never pass
    s_pos       = !item_q.sample[SampleW-1];
    above_floor = s_pos && (item_q.sample[SampleW-2:0] >
                            {{(SampleW-1-LevelW){1'b0}}, cfg.sample_floor});
    above_hit   = s_pos && (item_q.sample[SampleW-2:0] >
                            {{(SampleW-1-LevelW){1'b0}}, cfg.hit_level});

    // Saturating PE sum and fired channel count
    pe_sum = {1'b0, pe_q} + {{(PeW+2-SampleW){1'b0}}, item_q.sample[SampleW-2:0]};
    pe_new = pe_q;
    if (above_floor) begin
      pe_new = pe_sum[PeW] ? PeMax : pe_sum[PeW-1:0];
    end
    fired_new = fired_q;
    if (above_hit && (fired_q < FireW'(MaxChannels))) begin
      fired_new = fired_q + FireW'(1);
    end

    end_bin   = item_q.last_channel || item_q.last_bin;
    end_frame = item_q.last_bin;

    // Flash rules
    trig = (pe_new >= {{(PeW-PeMinW){1'b0}}, cfg.pe_min}) &&
           (CmpW'(fired_new) >= CmpW'(cfg.mult_min));
    bin_gap = bin_q - pend_bin_q;
    take = !pend_q || (bin_gap >= cfg.window_bins) ||
           ((bin_gap > cfg.min_gap) && (pe_new > pend_pe_q));
    new_flash = end_bin && trig && take;

    // Defaults: hold state
    pe_d       = pe_new;
    fired_d    = fired_new;
    pend_d     = pend_q;
    pend_bin_d = pend_bin_q;
    pend_pe_d  = pend_pe_q;
    bin_d      = bin_q;
    emit_close = 1'b0;
    emit_flush = 1'b0;

    if (end_bin) begin
      pe_d    = '0;
      fired_d = '0;
      if (trig && take) begin
        emit_close = pend_q;
        pend_d     = 1'b1;
        pend_bin_d = bin_q;
        pend_pe_d  = pe_new;
      end
      if (end_frame) begin
        emit_flush = pend_d;
        pend_d     = 1'b0;
        pend_bin_d = '0;
        pend_pe_d  = '0;
        bin_d      = '0;
      end else if (bin_q < BinMax) begin
        bin_d = bin_q + BinW'(1);
      end
    end

    // Flush reports the pending flash as it stands after this bin's trigger decision
    flush_bin = new_flash ? bin_q : pend_bin_q;

    // Window of the flash closed by a new trigger, and of the frame flush
    win_close = calc_window(pend_bin_q, bin_q, 1'b1, cfg);
    win_flush = calc_window(flush_bin, bin_q, 1'b0, cfg);

    res_close.window_start = win_close.first_bin;
    res_close.window_end   = win_close.end_bin;
    res_close.trigger_bin  = pend_bin_q;
    res_close.trigger_pe   = pend_pe_q;
    res_close.last_of_run  = !emit_flush;

    res_flush.window_start = win_flush.first_bin;
    res_flush.window_end   = win_flush.end_bin;
    res_flush.trigger_bin  = flush_bin;
    res_flush.trigger_pe   = new_flash ? pe_new : pend_pe_q;
    res_flush.last_of_run  = 1'b1;

    // Queue push
    wdata0   = emit_close ? res_close : res_flush;
    wdata1   = res_flush;
    push_cnt = 2'd0;
    if (proc) begin
      push_cnt = 2'(emit_close) + 2'(emit_flush);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q      <= '0;
      pe_q       <= '0;
      fired_q    <= '0;
      pend_q     <= 1'b0;
      pend_bin_q <= '0;
      pend_pe_q  <= '0;
    end else if (proc) begin
      bin_q      <= bin_d;
      pe_q       <= pe_d;
      fired_q    <= fired_d;
      pend_q     <= pend_d;
      pend_bin_q <= pend_bin_d;
      pend_pe_q  <= pend_pe_d;
    end
  end

  fwf_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .wdata0_i    (wdata0),
    .wdata1_i    (wdata1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // No pending flash means its trigger record is clear
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> ((pend_bin_q == '0) && (pend_pe_q == '0)))
    else $error("stale pending flash record");

  // A processed frame end restarts bin counting and drops the pending flash
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && item_q.last_bin) |=> ((bin_q == '0) && !pend_q))
    else $error("frame end did not restart");

  // The item register only waits while it holds an item
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> item_valid_q)
    else $error("stall with empty item register");

endmodule

[hw/rtl/fwf_regs.sv]
// APB register file holding the flash finder thresholds and window settings.
`timescale 1ns / 1ps

module fwf_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fwf_pkg::ApbDataW-1:0]  pwdata,
  output logic [fwf_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output fwf_pkg::cfg_t                 cfg_o
);
  import fwf_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_floor <= SampleFloorRst;
      cfg_q.hit_level    <= HitLevelRst;
      cfg_q.pe_min       <= PeMinRst;
      cfg_q.mult_min     <= MultMinRst;
      cfg_q.window_bins  <= WindowBinsRst;
      cfg_q.min_gap      <= MinGapRst;
      cfg_q.pre_bins     <= PreBinsRst;
      cfg_q.frame_bins   <= FrameBinsRst;
    end else if (wr_en) begin
      case (idx)
        REG_SAMPLE_FLOOR: cfg_q.sample_floor <= pwdata[LevelW-1:0];
        REG_HIT_LEVEL:    cfg_q.hit_level    <= pwdata[LevelW-1:0];
        REG_PE_MIN:       cfg_q.pe_min       <= pwdata[PeMinW-1:0];
        REG_MULT_MIN:     cfg_q.mult_min     <= pwdata[MultW-1:0];
        REG_WINDOW_BINS:  cfg_q.window_bins  <= pwdata[BinW-1:0];
        REG_MIN_GAP:      cfg_q.min_gap      <= pwdata[BinW-1:0];
        REG_PRE_BINS:     cfg_q.pre_bins     <= pwdata[PreW-1:0];
        REG_FRAME_BINS:   cfg_q.frame_bins   <= pwdata[BinW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_SAMPLE_FLOOR: prdata = {{(ApbDataW-LevelW){1'b0}}, cfg_q.sample_floor};
      REG_HIT_LEVEL:    prdata = {{(ApbDataW-LevelW){1'b0}}, cfg_q.hit_level};
      REG_PE_MIN:       prdata = {{(ApbDataW-PeMinW){1'b0}}, cfg_q.pe_min};
      REG_MULT_MIN:     prdata = {{(ApbDataW-MultW){1'b0}}, cfg_q.mult_min};
      REG_WINDOW_BINS:  prdata = {{(ApbDataW-BinW){1'b0}}, cfg_q.window_bins};
      REG_MIN_GAP:      prdata = {{(ApbDataW-BinW){1'b0}}, cfg_q.min_gap};
      REG_PRE_BINS:     prdata = {{(ApbDataW-PreW){1'b0}}, cfg_q.pre_bins};
      REG_FRAME_BINS:   prdata = {{(ApbDataW-BinW){1'b0}}, cfg_q.frame_bins};
      default:          prdata = '0;
    endcase
  end

endmodule

[hw/rtl/fwf_result_fifo.sv]
// Small result queue: takes up to two results a cycle, hands out one per transfer.
`timescale 1ns / 1ps

module fwf_result_fifo #(
  parameter int unsigned Depth = fwf_pkg::RESULT_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  fwf_pkg::result_t wdata0_i,
  input  fwf_pkg::result_t wdata1_i,
  output logic             room2_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fwf_pkg::result_t out_data_o
);
  import fwf_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room2_o     = (count_q <= CntW'(Depth - 2));

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_cnt_i) - CntW'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= wdata1_i;
    end
  end

  // Never more entries than slots
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  // A push only lands where there is space
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (count_q <= CntW'(Depth - 2)))
    else $error("push without room");

  // Pointer distance matches the fill level whenever the queue is not full
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CntW'(Depth)) |-> (PtrW'(wr_ptr_q - rd_ptr_q) == PtrW'(count_q)))
    else $error("pointer and count disagree");

endmodule
